>>> src/dbpg_pkg.sv
// Shared types, constants and helpers for the de Bruijn pattern generator.
// No dependencies; imported by the controller, datapath and top level.
package dbpg_pkg;

  // Alphabet and symbol encoding
  localparam logic [6:0] SYM_BASE    = 7'd97;   // ASCII 'a'
  localparam logic [4:0] ALPHA_MAX   = 5'd26;
  localparam logic [4:0] ALPHA_RESET = 5'd26;
  localparam logic [3:0] ORDER_RESET = 4'd4;
  localparam int         MAX_ORDER_DEFAULT = 8;

  // Register map (index = paddr[2])
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_ORDER = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic restart;    // load active config, clear word state
    logic emit;       // produce the digit of this item
    logic ext;        // one step of periodic extension
    logic strip;      // one step of strip / increment
    logic load_out;   // move finished result into the output register
  } dbpg_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic word_end;   // emitted digit is the last of the current word
    logic in_tail;    // emitting the trailing 'a' symbols
    logic ext_done;   // extension reached the order
    logic len_zero;   // every digit stripped: no more words
    logic at_top;     // digit under the strip pointer is the top digit
    logic divides;    // working length divides the order
  } dbpg_sts_t;

  // True when len divides n (both at most 16)
  function automatic logic divides(input logic [4:0] n, input logic [4:0] len);
    logic       hit;
    logic [9:0] prod;
    hit = 1'b0;
    for (int m = 1; m <= 16; m++) begin
      prod = 10'(len) * 10'(m);
      if (prod == 10'(n)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

>>> src/de_bruijn_pattern_generator.sv
// Top level of the de Bruijn pattern generator: configuration registers,
// controller and datapath. Depends on dbpg_pkg, dbpg_ctrl, dbpg_datapath.
//
// Emits the lexicographically smallest de Bruijn sequence B(k, n), one ASCII
// letter per input transfer, with out_tlast on the final symbol; the sequence
// then restarts on its own. An input with restart set reloads alphabet_size
// and order (clamped to 1..26 and 1..MAX_ORDER) and starts over; register
// writes have no effect until then. One item is in flight at a time: an item
// is accepted, emitted and handed off to the output register, and at the end
// of each Lyndon word a word-stepping loop extends the word digit by digit,
// closes the extension, strips top digits one by one and then increments a
// digit or ends the words, with another pass while the new length does not
// divide the order. The next item is accepted while a result waits in the
// output register.
module de_bruijn_pattern_generator #(
  parameter int MAX_ORDER = dbpg_pkg::MAX_ORDER_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] restart, [7:1] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [6:0] symbol, [7] zero
  output logic        out_tlast,    // last symbol of the sequence
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dbpg_pkg::*;

  logic [4:0] alpha_r;
  logic [3:0] order_r;
  logic       cfg_wr;
  dbpg_cmd_t  cmd;
  dbpg_sts_t  sts;
  logic [6:0] symbol;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      order_r <= ORDER_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ALPHA: alpha_r <= cfg_pwdata[4:0];
        REG_ORDER: order_r <= cfg_pwdata[3:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_ALPHA: cfg_prdata = {27'd0, alpha_r};
      REG_ORDER: cfg_prdata = {28'd0, order_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  dbpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dbpg_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_alpha  (alpha_r),
    .cfg_order  (order_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_symbol (symbol),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, symbol};

endmodule

>>> src/dbpg_datapath.sv
// Datapath of the de Bruijn pattern generator: word digit store, counters,
// active configuration and output register. Depends on dbpg_pkg.
module dbpg_datapath #(
  parameter int MAX_ORDER = dbpg_pkg::MAX_ORDER_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [4:0]           cfg_alpha,
  input  logic [3:0]           cfg_order,
  input  dbpg_pkg::dbpg_cmd_t  cmd,
  output dbpg_pkg::dbpg_sts_t  sts,
  output logic [6:0]           out_symbol,
  output logic                 out_last
);
  import dbpg_pkg::*;

  localparam int LW = $clog2(MAX_ORDER + 1);
  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam logic [4:0] MAX5 = 5'(MAX_ORDER);
  localparam int ORDER_INIT = (int'(ORDER_RESET) > MAX_ORDER) ? MAX_ORDER
                                                              : int'(ORDER_RESET);

  logic [4:0]    digits_r [MAX_ORDER];
  logic [LW-1:0] word_len_r;
  logic [LW-1:0] pos_r;
  logic [LW-1:0] tail_r;
  logic          tail_phase_r;
  logic [4:0]    alpha_r;
  logic [LW-1:0] order_r;
  logic [LW-1:0] idx_r;
  logic [LW-1:0] len_r;
  logic [4:0]    res_digit_r;
  logic          res_last_r;
  logic [6:0]    out_symbol_r;
  logic          out_last_r;

  logic [LW-1:0] rd_addr;
  logic [4:0]    rd_data;
  logic [4:0]    top;
  logic [LW-1:0] pos_inc;
  logic [LW-1:0] tail_inc;
  logic          tail_fin;
  logic [4:0]    alpha_sat;
  logic [4:0]    order5;
  logic [LW-1:0] order_sat;

  // Single read port into the digit store
  always_comb begin
    if (cmd.ext)        rd_addr = idx_r - len_r;
    else if (cmd.strip) rd_addr = len_r - LW'(1);
    else                rd_addr = pos_r;
  end
  assign rd_data = digits_r[rd_addr[IW-1:0]];

  assign top      = alpha_r - 5'd1;
  assign pos_inc  = pos_r + LW'(1);
  assign tail_inc = tail_r + LW'(1);
  assign tail_fin = tail_inc >= (order_r - LW'(1));

  // Clamp configuration into the supported range
  assign order5 = {1'b0, cfg_order};
  always_comb begin
    if (cfg_alpha == 5'd0)          alpha_sat = 5'd1;
    else if (cfg_alpha > ALPHA_MAX) alpha_sat = ALPHA_MAX;
    else                            alpha_sat = cfg_alpha;
    if (order5 == 5'd0)             order_sat = LW'(1);
    else if (order5 > MAX5)         order_sat = LW'(MAX_ORDER);
    else                            order_sat = LW'(order5);
  end

  // Status to controller
  always_comb begin
    sts.word_end = pos_inc >= word_len_r;
    sts.in_tail  = tail_phase_r;
    sts.ext_done = idx_r >= order_r;
    sts.len_zero = len_r == '0;
    sts.at_top   = rd_data == top;
    sts.divides  = divides(5'(order_r), 5'(len_r));
  end

  // Word state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= ALPHA_RESET;
      order_r      <= LW'(ORDER_INIT);
      for (int j = 0; j < MAX_ORDER; j++) digits_r[j] <= 5'd0;
      word_len_r   <= LW'(1);
      pos_r        <= '0;
      tail_phase_r <= 1'b0;
      tail_r       <= '0;
      idx_r        <= '0;
      len_r        <= '0;
      res_digit_r  <= 5'd0;
      res_last_r   <= 1'b0;
    end else if (cmd.restart) begin
      alpha_r      <= alpha_sat;
      order_r      <= order_sat;
      for (int j = 0; j < MAX_ORDER; j++) digits_r[j] <= 5'd0;
      word_len_r   <= LW'(1);
      pos_r        <= '0;
      tail_phase_r <= 1'b0;
      tail_r       <= '0;
    end else if (cmd.emit) begin
      if (tail_phase_r) begin
        // trailing 'a' run
        res_digit_r <= 5'd0;
        res_last_r  <= tail_fin;
        tail_r      <= tail_inc;
        if (tail_fin) begin
          for (int j = 0; j < MAX_ORDER; j++) digits_r[j] <= 5'd0;
          word_len_r   <= LW'(1);
          pos_r        <= '0;
          tail_phase_r <= 1'b0;
          tail_r       <= '0;
        end
      end else begin
        res_digit_r <= rd_data;
        res_last_r  <= 1'b0;
        if (sts.word_end) begin
          pos_r <= '0;
          idx_r <= word_len_r;
          len_r <= word_len_r;
        end else begin
          pos_r <= pos_inc;
        end
      end
    end else if (cmd.ext) begin
      // periodic extension, one position per cycle
      if (!sts.ext_done) begin
        digits_r[idx_r[IW-1:0]] <= rd_data;
        idx_r <= idx_r + LW'(1);
      end else begin
        len_r <= order_r;
      end
    end else if (cmd.strip) begin
      if (sts.len_zero) begin
        word_len_r <= LW'(1);
        if (order_r <= LW'(1)) begin
          res_last_r <= 1'b1;
          for (int j = 0; j < MAX_ORDER; j++) digits_r[j] <= 5'd0;
          pos_r        <= '0;
          tail_phase_r <= 1'b0;
          tail_r       <= '0;
        end else begin
          tail_phase_r <= 1'b1;
          tail_r       <= '0;
        end
      end else if (sts.at_top) begin
        len_r <= len_r - LW'(1);
      end else begin
        digits_r[rd_addr[IW-1:0]] <= rd_data + 5'd1;
        if (sts.divides) word_len_r <= len_r;
        else             idx_r      <= len_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_symbol_r <= SYM_BASE + {2'b00, res_digit_r};
      out_last_r   <= res_last_r;
    end
  end

  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

>>> src/dbpg_ctrl.sv
// Controller of the de Bruijn pattern generator: item sequencing, Lyndon
// word stepping and output valid. Depends on dbpg_pkg.
module dbpg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_restart,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  dbpg_pkg::dbpg_sts_t  sts,
  output dbpg_pkg::dbpg_cmd_t  cmd
);
  import dbpg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMIT  = 3'd1;
  localparam logic [2:0] S_EXT   = 3'd2;
  localparam logic [2:0] S_STRIP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;
  logic       out_free;

  assign in_tready = state_r == S_IDLE;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.restart = in_restart;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (!sts.in_tail && sts.word_end) state_nxt = S_EXT;
        else                              state_nxt = S_DONE;
      end
      S_EXT: begin
        cmd.ext = 1'b1;
        if (sts.ext_done) state_nxt = S_STRIP;
      end
      S_STRIP: begin
        cmd.strip = 1'b1;
        if (sts.len_zero)                   state_nxt = S_DONE;
        else if (!sts.at_top && sts.divides) state_nxt = S_DONE;
        else if (!sts.at_top)                state_nxt = S_EXT;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared on transfer
  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted item always goes to the emit step next
  a_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EMIT)
    else $error("accepted item did not move to emit");

  // The output register is only loaded when it is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("output overwritten before transfer");

  // A result only appears after the done step
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("output valid raised outside done step");

  // Only one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.restart, cmd.emit, cmd.ext, cmd.strip, cmd.load_out}))
    else $error("conflicting datapath commands");

endmodule
